@@ rtl/core/ratio_test_candidate_heap_unit_assert.svh @@
// Assertion macros for the ratio-test candidate heap.
`ifndef RATIO_TEST_CANDIDATE_HEAP_UNIT_ASSERT_SVH
`define RATIO_TEST_CANDIDATE_HEAP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RTCH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define RTCH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define RTCH_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RTCH_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/rtch_pkg.sv @@
// Shared types and constants for the ratio-test candidate heap.
package rtch_pkg;
	localparam int HeapDepth = 64;
	localparam int PosBits = $clog2(HeapDepth);
	localparam int CntBits = PosBits + 1;
	localparam int FracBits = 16;
	localparam int IndexBits = 16;
	localparam int SumBits = 40;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_OFFER = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [2:0] ACT_ADDED = 3'd0;
	localparam logic [2:0] ACT_REPLACED = 3'd1;
	localparam logic [2:0] ACT_DISCARDED = 3'd2;
	localparam logic [2:0] ACT_FULL = 3'd3;
	localparam logic [2:0] ACT_ZERO_PIVOT = 3'd4;
	localparam logic [2:0] ACT_OTHER = 3'd5;

	typedef struct packed {
		logic [1:0] op;
		logic signed [31:0] reduced_cost;
		logic signed [31:0] pivot_coef;
		logic [31:0] bound_range;
		logic [IndexBits-1:0] var_index;
		logic [5:0] read_pos;
	} in_item_t;

	typedef struct packed {
		logic [2:0] action;
		logic [6:0] entry_count;
		logic [SumBits-1:0] slope_total;
		logic signed [31:0] entry_score;
		logic [IndexBits-1:0] entry_index;
	} out_item_t;

	// One heap entry as stored in memory.
	typedef struct packed {
		logic signed [31:0] score;
		logic [IndexBits-1:0] vidx;
		logic [31:0] slope;
	} entry_t;

	function automatic logic key_less(input entry_t a, input entry_t b);
		if (a.score != b.score) return a.score < b.score;
		return a.vidx < b.vidx;
	endfunction
endpackage

@@ rtl/core/ratio_test_candidate_heap_unit.sv @@
// Top level: ratio-test candidate heap with serial divider and sift sequencer.
// From acceptance to a valid result: clear, op 3 and a zero pivot go straight to the done state;
// a read passes the read and read-wait states; an offer runs a 48-step division and a decide state,
// then per level an insertion sift-up (parent read, compare) or a replacement sift-down (left, right, compare).
// One transaction is in work at a time; the next is taken once the result has been accepted.
// Asynchronous active-low reset empties the heap and zeroes the sum and the slope limit.
`include "ratio_test_candidate_heap_unit_assert.svh"
module ratio_test_candidate_heap_unit import rtch_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [31:0] cfg_data
);
	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_DIV    = 11'b00000000010,
		ST_DECIDE = 11'b00000000100,
		ST_UPRD   = 11'b00000001000,
		ST_UPCMP  = 11'b00000010000,
		ST_DNRDL  = 11'b00000100000,
		ST_DNRDR  = 11'b00001000000,
		ST_DNCMP  = 11'b00010000000,
		ST_READ   = 11'b00100000000,
		ST_RDWAIT = 11'b01000000000,
		ST_DONE   = 11'b10000000000
	} state_t;

	state_t state_q;
	in_item_t item_q;
	logic [31:0] limit_q;
	logic [CntBits-1:0] count_q;
	logic [SumBits-1:0] sum_q;
	entry_t new_q;
	entry_t top_q;
	entry_t left_q;
	logic [PosBits-1:0] hole_q;
	logic [CntBits-1:0] child_q;
	logic [2:0] act_q;

	logic div_start, div_done;
	logic signed [31:0] div_quot;
	logic mem_we;
	logic [PosBits-1:0] mem_waddr, mem_raddr;
	entry_t mem_wdata, mem_rdata;
	logic [63:0] slope_prod;
	logic [31:0] slope_sat;
	logic [SumBits:0] add_sum;
	logic [SumBits-1:0] sum_plus;
	logic [SumBits-1:0] trial_base;
	logic [SumBits:0] trial_raw;
	logic [SumBits-1:0] trial_sum;
	logic [CntBits-1:0] parent;
	logic [CntBits-1:0] lchild;
	logic [31:0] abs_piv;

	// Form the candidate slope of the offered entry: bound range times the absolute pivot, saturated.
	assign abs_piv = item_q.pivot_coef[31] ? 32'(-item_q.pivot_coef) : 32'(item_q.pivot_coef);
	assign slope_prod = 64'(item_q.bound_range) * 64'(abs_piv);
	assign slope_sat = (slope_prod[63:32+FracBits] != '0) ? 32'hffffffff
		: slope_prod[31+FracBits:FracBits];

	assign add_sum = {1'b0, sum_q} + (SumBits+1)'(new_q.slope);
	assign sum_plus = add_sum[SumBits] ? {SumBits{1'b1}} : add_sum[SumBits-1:0];
	assign trial_base = (sum_q > SumBits'(top_q.slope)) ? sum_q - SumBits'(top_q.slope) : '0;
	assign trial_raw = {1'b0, trial_base} + (SumBits+1)'(new_q.slope);
	assign trial_sum = trial_raw[SumBits] ? {SumBits{1'b1}} : trial_raw[SumBits-1:0];

	assign parent = (CntBits'(hole_q) - CntBits'(1)) >> 1;
	assign lchild = {hole_q, 1'b1};

	assign in_ready = (state_q == ST_IDLE) && !out_valid;
	assign cfg_ready = 1'b1;
	assign div_start = (state_q == ST_IDLE) && in_valid && in_ready && in_data.op == OP_OFFER
		&& in_data.pivot_coef != 32'sd0;

	rtch_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(in_data.reduced_cost), .den(in_data.pivot_coef),
		.done(div_done), .quot(div_quot)
	);

	rtch_heap_mem u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	// Memory port control: reads and writes follow the sequencer state.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = hole_q;
		mem_wdata = new_q;
		mem_raddr = '0;
		case (state_q)
			ST_IDLE: mem_raddr = in_data.read_pos;
			ST_READ: mem_raddr = item_q.read_pos;
			ST_UPRD: mem_raddr = parent[PosBits-1:0];
			ST_UPCMP: begin
				mem_we = 1'b1;
				if (hole_q != '0 && key_less(mem_rdata, new_q)) mem_wdata = mem_rdata;
			end
			ST_DNRDL: begin
				mem_raddr = lchild[PosBits-1:0];
				// A hole without children takes the new entry.
				if (lchild >= count_q) mem_we = 1'b1;
			end
			ST_DNRDR: mem_raddr = PosBits'(lchild + CntBits'(1));
			ST_DNCMP: begin
				mem_we = 1'b1;
				if ((child_q + CntBits'(1) < count_q) && key_less(left_q, mem_rdata)) begin
					if (key_less(new_q, mem_rdata)) mem_wdata = mem_rdata;
				end else if (key_less(new_q, left_q)) begin
					mem_wdata = left_q;
				end
			end
			default: mem_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			count_q <= '0;
			sum_q <= '0;
			limit_q <= '0;
		end else begin
			if (cfg_valid) limit_q <= cfg_data;
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						if (in_data.op == OP_CLEAR) begin
							count_q <= '0;
							sum_q <= '0;
							state_q <= ST_DONE;
						end else if (in_data.op == OP_READ) begin
							state_q <= ST_READ;
						end else if (in_data.op == OP_OFFER && in_data.pivot_coef != 32'sd0) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DIV: if (div_done) state_q <= ST_DECIDE;
				ST_DECIDE: begin
					if (sum_q <= SumBits'(limit_q) || count_q == '0
						|| (new_q.score <= top_q.score && trial_sum < SumBits'(limit_q))) begin
						if (count_q >= CntBits'(HeapDepth)) begin
							state_q <= ST_DONE;
						end else begin
							sum_q <= sum_plus;
							count_q <= count_q + CntBits'(1);
							state_q <= ST_UPRD;
						end
					end else if (new_q.score <= top_q.score) begin
						sum_q <= trial_sum;
						state_q <= ST_DNRDL;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_UPRD: state_q <= ST_UPCMP;
				ST_UPCMP: begin
					if (hole_q != '0 && key_less(mem_rdata, new_q)) state_q <= ST_UPRD;
					else state_q <= ST_DONE;
				end
				ST_DNRDL: begin
					if (lchild >= count_q) state_q <= ST_DONE;
					else state_q <= ST_DNRDR;
				end
				ST_DNRDR: state_q <= ST_DNCMP;
				ST_DNCMP: begin
					if (mem_wdata != new_q) state_q <= ST_DNRDL;
					else state_q <= ST_DONE;
				end
				ST_READ: state_q <= ST_RDWAIT;
				ST_RDWAIT: state_q <= ST_DONE;
				ST_DONE: begin
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the item in work.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					item_q <= in_data;
					new_q.vidx <= in_data.var_index;
					new_q.score <= '0;
					act_q <= (in_data.op == OP_OFFER && in_data.pivot_coef == 32'sd0)
						? ACT_ZERO_PIVOT : ACT_OTHER;
				end
			end
			ST_DIV: begin
				new_q.slope <= slope_sat;
				top_q <= mem_rdata;
				if (div_done) new_q.score <= div_quot;
			end
			ST_DECIDE: begin
				child_q <= CntBits'(1);
				if (sum_q <= SumBits'(limit_q) || count_q == '0
					|| (new_q.score <= top_q.score && trial_sum < SumBits'(limit_q))) begin
					act_q <= (count_q >= CntBits'(HeapDepth)) ? ACT_FULL : ACT_ADDED;
					hole_q <= PosBits'(count_q);
				end else if (new_q.score <= top_q.score) begin
					act_q <= ACT_REPLACED;
					hole_q <= '0;
				end else begin
					act_q <= ACT_DISCARDED;
				end
			end
			ST_UPCMP: if (hole_q != '0 && key_less(mem_rdata, new_q)) hole_q <= parent[PosBits-1:0];
			ST_DNRDL: child_q <= lchild;
			ST_DNRDR: left_q <= mem_rdata;
			ST_DNCMP: begin
				if (mem_wdata != new_q) begin
					if (mem_wdata == mem_rdata && (child_q + CntBits'(1) < count_q)
						&& key_less(left_q, mem_rdata))
						hole_q <= PosBits'(child_q + CntBits'(1));
					else
						hole_q <= child_q[PosBits-1:0];
				end
			end
			ST_RDWAIT: begin
				if (CntBits'(item_q.read_pos) < count_q) begin
					new_q.score <= mem_rdata.score;
					new_q.vidx <= mem_rdata.vidx;
				end else begin
					new_q.score <= '0;
					new_q.vidx <= '0;
				end
			end
			ST_DONE: begin
				out_data.action <= act_q;
				out_data.entry_count <= 7'(count_q);
				out_data.slope_total <= sum_q;
				out_data.entry_score <= new_q.score;
				out_data.entry_index <= (item_q.op == OP_CLEAR || item_q.op == 2'd3) ? '0
					: new_q.vidx;
			end
			default: ;
		endcase
	end

	`RTCH_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CntBits'(HeapDepth))
	`RTCH_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !in_ready)
	`RTCH_ASSERT_NXT(a_done_valid, clk, arst_n, state_q == ST_DONE, out_valid)
endmodule

@@ rtl/core/rtch_divider.sv @@
// Serial signed Q16.16 divider with saturation, one quotient bit per cycle.
module rtch_divider import rtch_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [31:0] num,
	input logic signed [31:0] den,
	output logic done,
	output logic signed [31:0] quot
);
	localparam int NumBits = 32 + FracBits;

	logic [NumBits-1:0] dvd_q;
	logic [NumBits-1:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dsr_q;
	logic neg_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [33:0] trial;
	logic [NumBits:0] mag;

	assign trial = {rem_q, dvd_q[NumBits-1]} - {2'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(NumBits);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {(num[31] ? 32'(-num) : 32'(num)), {FracBits{1'b0}}};
			dsr_q <= den[31] ? 32'(-den) : 32'(den);
			neg_q <= num[31] ^ den[31];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NumBits-2:0], 1'b0};
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[NumBits-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], dvd_q[NumBits-1]};
				quo_q <= {quo_q[NumBits-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		mag = {1'b0, quo_q};
		if (neg_q) begin
			if (mag > (NumBits+1)'(33'h080000000)) quot = 32'sh80000000;
			else quot = 32'(-mag[31:0]);
		end else begin
			if (mag > (NumBits+1)'(33'h07fffffff)) quot = 32'sh7fffffff;
			else quot = mag[31:0];
		end
	end
endmodule

@@ rtl/core/rtch_heap_mem.sv @@
// Entry memory of the heap, one write and one registered read port.
module rtch_heap_mem import rtch_pkg::*; (
	input logic clk,
	input logic we,
	input logic [PosBits-1:0] waddr,
	input entry_t wdata,
	input logic [PosBits-1:0] raddr,
	output entry_t rdata
);
	entry_t mem [HeapDepth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
